/* design/bsps_pkg.sv */
package bsps_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int WORD_DEFAULT  = 32;

   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int POP_W    = 16;
   localparam int RESULT_W = 42;
   localparam int CAP_W    = 11;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_CAPACITY = '0;

   localparam logic [OP_W-1:0] OP_SIZE   = 3'd0;
   localparam logic [OP_W-1:0] OP_EMPTY  = 3'd1;
   localparam logic [OP_W-1:0] OP_TOP    = 3'd2;
   localparam logic [OP_W-1:0] OP_PUSH   = 3'd3;
   localparam logic [OP_W-1:0] OP_POPSUM = 3'd4;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef logic signed [RESULT_W-1:0] result_type;

endpackage

/* design/bounded_stack_with_pop_sum_top.sv */
// channel   direction  handshake                 payload
// req       in         req_valid / req_stall     req_operation, req_push_value, req_pop_count
// rsp       out        rsp_valid / rsp_stall     rsp_status, rsp_result_value
// csr       in         csr_psel/penable/pwrite   csr_paddr, csr_pwdata -> csr_prdata
//
// A push that fits is written and gets no response; a full push answers STATUS_FULL.
// Size and empty answer directly; top adds one registered memory read. Popsum walks the
// n words popped: the single read port and the one accumulator take one word a cycle.
// Reset clears the word count and sets capacity to 1024; memory contents are kept.
// A result waits in the output register while rsp_stall is high; a new beat is
// accepted meanwhile, but req_stall is high whenever the block is not idle.
module bounded_stack_with_pop_sum_top
   import bsps_pkg::*;
#(
   parameter int STACK_DEPTH = DEPTH_DEFAULT,
   parameter int WORD_WIDTH  = WORD_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [OP_W-1:0]              req_operation,
   input  logic signed [VALUE_W-1:0]    req_push_value,
   input  logic [POP_W-1:0]             req_pop_count,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_status,
   output logic signed [RESULT_W-1:0]   rsp_result_value,

   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [CSR_DATA_W-1:0]        csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready
);

   localparam int ADDR_W  = $clog2(STACK_DEPTH);
   localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
   localparam int CMP_W   = (CNT_W > POP_W) ? CNT_W : POP_W;
   localparam int CAPC_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_TOP  = 2'd1;
   localparam logic [1:0] S_POP  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      remain_ff, remain_in;
   result_type            acc_ff, acc_in;
   logic                  status_ff, status_in;
   logic [CAP_W-1:0]      capacity_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_status_ff;
   result_type            rsp_value_ff;

   logic [WORD_WIDTH-1:0] stack_ff [STACK_DEPTH];
   logic [WORD_WIDTH-1:0] rd_data_ff;
   logic                  rd_en, wr_en;
   logic [ADDR_W-1:0]     rd_addr, wr_addr;

   logic                  req_take, out_free, full, csr_write;
   logic [CNT_W-1:0]      count_m1, pop_n;
   result_type            rd_word, acc_sum;

   assign req_stall   = (state_ff != S_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign count_m1    = count_ff - CNT_W'(1);
   assign rd_addr     = count_m1[ADDR_W-1:0];
   assign wr_addr     = count_ff[ADDR_W-1:0];
   assign rd_word     = RESULT_W'($signed(rd_data_ff));
   assign acc_sum     = acc_ff + rd_word;
   assign full        = (CAPC_W'(count_ff) >= CAPC_W'(capacity_ff))
                     || (count_ff >= CNT_W'(STACK_DEPTH));
   assign pop_n       = (CMP_W'(req_pop_count) > CMP_W'(count_ff)) ? count_ff
                                                                   : CNT_W'(req_pop_count);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      acc_in       = acc_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               status_in = STATUS_OK;
               case (req_operation)
                  OP_SIZE: begin
                     acc_in   = RESULT_W'(count_ff);
                     state_in = S_DONE;
                  end
                  OP_EMPTY: begin
                     acc_in   = (count_ff == '0) ? RESULT_W'(1) : '0;
                     state_in = S_DONE;
                  end
                  OP_TOP: begin
                     if (count_ff == '0) begin
                        acc_in   = '1;
                        state_in = S_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_TOP;
                     end
                  end
                  OP_PUSH: begin
                     if (full) begin
                        status_in = STATUS_FULL;
                        acc_in    = '0;
                        state_in  = S_DONE;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_POPSUM: begin
                     acc_in = '0;
                     if (count_ff == '0) begin
                        acc_in   = '1;
                        state_in = S_DONE;
                     end else if (pop_n == '0) begin
                        state_in = S_DONE;
                     end else begin
                        // first read goes out now, the sum follows one word a cycle
                        rd_en     = 1'b1;
                        count_in  = count_m1;
                        remain_in = pop_n;
                        state_in  = S_POP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_TOP: begin
            acc_in   = rd_word;
            state_in = S_DONE;
         end
         S_POP: begin
            acc_in    = acc_sum;
            remain_in = remain_ff - CNT_W'(1);
            if (remain_ff == CNT_W'(1)) begin
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               count_in = count_m1;
            end
         end
         S_DONE: begin
            // hold the result until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      acc_ff    <= acc_in;
      status_ff <= status_in;
      if (state_ff == S_DONE && out_free) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_ff[wr_addr] <= req_push_value[WORD_WIDTH-1:0];
      end
      if (rd_en) begin
         rd_data_ff <= stack_ff[rd_addr];
      end
   end

   assign csr_write = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[CSR_ADDR_W-1:2] == REG_CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_write) begin
         capacity_ff <= csr_pwdata[CAP_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_CAPACITY)
                     ? CSR_DATA_W'(capacity_ff) : '0;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = rsp_value_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("word count beyond store depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      req_take && req_operation == OP_PUSH && !full |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("accepted push did not advance the count");

   a_pop_remain: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP |-> remain_ff != '0 && (remain_ff - CNT_W'(1)) <= count_ff)
      else $error("popsum walk runs past the stack bottom");

   a_done_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && out_free |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished result not presented");

   a_out_held: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && !out_free |=> state_ff == S_DONE)
      else $error("result dropped while output stalled");

endmodule
